// File: sv/bsa_pkg.sv
package bsa_pkg;

    localparam int CUSTOMERS   = 5;
    localparam int RESOURCES   = 3;
    localparam int COUNT_WIDTH = 16;

    // Packing of registers and stream fields (fixed by the interface)
    localparam int FIELD_W     = 16;
    localparam int CFG_W       = 48;
    localparam int REG_COUNT   = CUSTOMERS + 1;
    localparam int CFG_IDX_W   = $clog2(REG_COUNT);
    localparam int REG_TOTAL   = 0;
    localparam int REG_MAX_BASE = 1;

    localparam int CUST_FIELD_W = 3;
    localparam int STATUS_W     = 3;
    localparam int IN_CNT_LSB   = CUST_FIELD_W;
    localparam int OUT_AVL_LSB  = STATUS_W;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 56;

    // Sum of all allocations and the safety-check work vector
    localparam int SUM_W  = COUNT_WIDTH + $clog2(CUSTOMERS + 1);
    localparam int WORK_W = SUM_W + 1;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 3'd0,
        ST_OVER_NEED  = 3'd1,
        ST_OVER_AVAIL = 3'd2,
        ST_UNSAFE     = 3'd3,
        ST_RELEASED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RELEASE,
        S_ALLOC,
        S_INIT,
        S_SCAN,
        S_ROLLBACK,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    give_back;
        logic    alloc;
        logic    init;
        logic    step;
        logic    rollback;
        logic    set_status;
        status_t code;
        logic    report;
    } cmd_t;

    typedef struct packed {
        logic is_release;
        logic cust_ok;
        logic over_need;
        logic over_avail;
        logic fit_any;
        logic all_done;
        logic out_free;
    } stat_t;

endpackage

// File: sv/bsa_datapath.sv
module bsa_datapath
    import bsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    count_t total_reg [RESOURCES];
    count_t max_reg   [CUSTOMERS][RESOURCES];
    count_t alloc_reg [CUSTOMERS][RESOURCES];
    logic [SUM_W-1:0]  sum_reg  [RESOURCES];
    logic [WORK_W-1:0] work_reg [RESOURCES];
    logic [CUSTOMERS-1:0] done_reg;

    // Latched request
    logic                    op_reg;
    logic [CUST_FIELD_W-1:0] cust_reg;
    count_t                  cnt_reg [RESOURCES];
    status_t                 status_reg;

    logic    out_valid_reg;
    status_t out_status_reg;
    count_t  out_avail_reg [RESOURCES];

    logic [CUSTOMERS-1:0] cust_hit;
    logic                 cust_ok;
    count_t sel_alloc [RESOURCES];
    count_t sel_max   [RESOURCES];
    count_t need      [RESOURCES];
    count_t avail     [RESOURCES];
    count_t give      [RESOURCES];
    count_t pick_alloc [RESOURCES];
    logic [CUSTOMERS-1:0] fit_vec;
    logic [CUSTOMERS-1:0] pick_vec;
    logic over_need;
    logic over_avail;

    always_comb
    begin
        for (int c = 0; c < CUSTOMERS; c++)
        begin
            cust_hit[c] = (32'(cust_reg) == c);
        end
        cust_ok    = (32'(cust_reg) < CUSTOMERS);
        over_need  = 1'b0;
        over_avail = 1'b0;
        for (int r = 0; r < RESOURCES; r++)
        begin
            sel_alloc[r] = '0;
            sel_max[r]   = '0;
            for (int c = 0; c < CUSTOMERS; c++)
            begin
                if (cust_hit[c])
                begin
                    sel_alloc[r] = alloc_reg[c][r];
                    sel_max[r]   = max_reg[c][r];
                end
            end
            need[r]  = (sel_max[r] > sel_alloc[r]) ? sel_max[r] - sel_alloc[r] : '0;
            avail[r] = (SUM_W'(total_reg[r]) > sum_reg[r])
                     ? COUNT_WIDTH'(SUM_W'(total_reg[r]) - sum_reg[r]) : '0;
            give[r]  = (cnt_reg[r] < sel_alloc[r]) ? cnt_reg[r] : sel_alloc[r];
            if (cnt_reg[r] > need[r])
                over_need = 1'b1;
            if (cnt_reg[r] > avail[r])
                over_avail = 1'b1;
        end
    end

    // Safety scan: every unfinished customer compared against work at once
    always_comb
    begin
        for (int c = 0; c < CUSTOMERS; c++)
        begin
            fit_vec[c] = !done_reg[c];
            for (int r = 0; r < RESOURCES; r++)
            begin
                if ((WORK_W + 1)'(max_reg[c][r]) >
                    (WORK_W + 1)'(alloc_reg[c][r]) + (WORK_W + 1)'(work_reg[r]))
                    fit_vec[c] = 1'b0;
            end
        end
        pick_vec = fit_vec & (~fit_vec + CUSTOMERS'(1));
        for (int r = 0; r < RESOURCES; r++)
        begin
            pick_alloc[r] = '0;
            for (int c = 0; c < CUSTOMERS; c++)
            begin
                if (pick_vec[c])
                    pick_alloc[r] = pick_alloc[r] | alloc_reg[c][r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < RESOURCES; r++)
            begin
                total_reg[r] <= '0;
                sum_reg[r]   <= '0;
                work_reg[r]  <= '0;
                for (int c = 0; c < CUSTOMERS; c++)
                begin
                    max_reg[c][r]   <= '0;
                    alloc_reg[c][r] <= '0;
                end
            end
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                for (int r = 0; r < RESOURCES; r++)
                begin
                    if (cfg_index == CFG_IDX_W'(REG_TOTAL))
                        total_reg[r] <= cfg_data[FIELD_W*r +: COUNT_WIDTH];
                    for (int c = 0; c < CUSTOMERS; c++)
                    begin
                        if (cfg_index == CFG_IDX_W'(REG_MAX_BASE + c))
                            max_reg[c][r] <= cfg_data[FIELD_W*r +: COUNT_WIDTH];
                    end
                end
            end
            for (int r = 0; r < RESOURCES; r++)
            begin
                if (cmd.alloc)
                    sum_reg[r] <= sum_reg[r] + SUM_W'(cnt_reg[r]);
                else if (cmd.rollback)
                    sum_reg[r] <= sum_reg[r] - SUM_W'(cnt_reg[r]);
                else if (cmd.give_back && cust_ok)
                    sum_reg[r] <= sum_reg[r] - SUM_W'(give[r]);
                for (int c = 0; c < CUSTOMERS; c++)
                begin
                    if (cust_hit[c])
                    begin
                        if (cmd.alloc)
                            alloc_reg[c][r] <= alloc_reg[c][r] + cnt_reg[r];
                        else if (cmd.rollback)
                            alloc_reg[c][r] <= alloc_reg[c][r] - cnt_reg[r];
                        else if (cmd.give_back)
                            alloc_reg[c][r] <= alloc_reg[c][r] - give[r];
                    end
                end
                if (cmd.init)
                    work_reg[r] <= WORK_W'(avail[r]);
                else if (cmd.step)
                    work_reg[r] <= work_reg[r] + WORK_W'(pick_alloc[r]);
            end
            if (cmd.init)
                done_reg <= '0;
            else if (cmd.step)
                done_reg <= done_reg | pick_vec;
            if (cmd.report)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= s_tuser;
            cust_reg <= s_tdata[CUST_FIELD_W-1:0];
            for (int r = 0; r < RESOURCES; r++)
                cnt_reg[r] <= s_tdata[IN_CNT_LSB + FIELD_W*r +: COUNT_WIDTH];
        end
        if (cmd.set_status)
            status_reg <= cmd.code;
        if (cmd.report)
        begin
            out_status_reg <= status_reg;
            for (int r = 0; r < RESOURCES; r++)
                out_avail_reg[r] <= avail[r];
        end
    end

    always_comb
    begin
        m_tdata = '0;
        m_tdata[STATUS_W-1:0] = out_status_reg;
        for (int r = 0; r < RESOURCES; r++)
            m_tdata[OUT_AVL_LSB + FIELD_W*r +: COUNT_WIDTH] = out_avail_reg[r];
    end

    assign m_tvalid        = out_valid_reg;
    assign stat.is_release = op_reg;
    assign stat.cust_ok    = cust_ok;
    assign stat.over_need  = over_need;
    assign stat.over_avail = over_avail;
    assign stat.fit_any    = |fit_vec;
    assign stat.all_done   = &done_reg;
    assign stat.out_free   = !out_valid_reg || m_tready;

endmodule

// File: sv/bsa_ctrl.sv
module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_GRANTED;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.is_release)
                    state_next = S_RELEASE;
                else if (!stat.cust_ok || stat.over_need)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_OVER_NEED;
                    state_next     = S_REPORT;
                end
                else if (stat.over_avail)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_OVER_AVAIL;
                    state_next     = S_REPORT;
                end
                else
                    state_next = S_ALLOC;
            end
            S_RELEASE:
            begin
                cmd.give_back  = 1'b1;
                cmd.set_status = 1'b1;
                cmd.code       = ST_RELEASED;
                state_next     = S_REPORT;
            end
            S_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.fit_any)
                    cmd.step = 1'b1;
                else if (stat.all_done)
                begin
                    cmd.set_status = 1'b1;
                    cmd.code       = ST_GRANTED;
                    state_next     = S_REPORT;
                end
                else
                    state_next = S_ROLLBACK;
            end
            S_ROLLBACK:
            begin
                cmd.rollback   = 1'b1;
                cmd.set_status = 1'b1;
                cmd.code       = ST_UNSAFE;
                state_next     = S_REPORT;
            end
            S_REPORT:
            begin
                if (stat.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// File: sv/bankers_safety_allocator_core.sv
// Banker's-algorithm allocator, five customers by three resource types.
// Config: cfg_we/cfg_index/cfg_data write total_units (index 0) and the
//   per-customer max claims (index 1..5), three 16-bit fields each. Write
//   only while the block is idle.
// Input stream: one request per handshake; s_tuser is the opcode
//   (request/release), s_tdata carries customer and three unit counts.
// Output stream: one result per request: status plus the units left
//   available after the request.
// Sequence, accepting edge to m_tvalid: a rejected request goes through
//   evaluate and report, a release through evaluate, give back and
//   report. An admitted request runs allocate, init and the safety scan,
//   which finishes one customer per cycle (lowest fitting index) until
//   none fits, then rollback if unsafe, then report. The next request is
//   taken the cycle after the result loads; the scan loop sets the rate.
// Only one request is in work at a time; a new one is taken once the
//   previous result has been loaded into the output register.
// Reset clears config, allocations and the scan state; no result pending.
// If m_tready is low the result waits in its register; the block holds
//   in its report step and takes no new request until that slot frees.
module bankers_safety_allocator_core
    import bsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // customer[2:0], count_a[18:3],
                                             // count_b[34:19], count_c[50:35]
    input  logic                   s_tuser,  // opcode: 0 request, 1 release
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata   // status[2:0], avail_a[18:3],
                                             // avail_b[34:19], avail_c[50:35]
);

    cmd_t  cmd;
    stat_t stat;

    // FSM: sequences evaluate / release / allocate / init / scan / rollback / report
    bsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Config, allocation table, sums, work vector and output register
    bsa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: sv/bsa_checker.sv
module bsa_checker
    import bsa_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // status codes stay within the defined set
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] == ST_GRANTED
                   || m_tdata[STATUS_W-1:0] == ST_OVER_NEED
                   || m_tdata[STATUS_W-1:0] == ST_OVER_AVAIL
                   || m_tdata[STATUS_W-1:0] == ST_UNSAFE
                   || m_tdata[STATUS_W-1:0] == ST_RELEASED))
        else $error("bad status code");

    // a fresh result needs at least one request behind it
    a_result_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without request in work");

endmodule

bind bankers_safety_allocator_core bsa_checker u_bsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
